FILE: rtl/gha_pkg.sv
// Package for the generational handle allocator.
// Holds the field types, command and status codes, slot entry layout and state encoding.
// Depends on nothing; gha_if, gha_stack, the top level and the checker refer to it by scoped names.
package gha_pkg;

    localparam int NUM_SLOTS_DEFAULT = 256;

    typedef logic [1:0]  command_t;
    typedef logic [7:0]  index_field_t;
    typedef logic [31:0] generation_t;
    typedef logic [3:0]  kind_t;
    typedef logic [1:0]  status_t;

    localparam command_t CMD_ALLOC = 2'd0;
    localparam command_t CMD_FREE  = 2'd1;
    localparam command_t CMD_CHECK = 2'd2;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_INVALID = 2'd1;
    localparam status_t STATUS_FULL    = 2'd2;

    localparam kind_t KIND_INVALID = 4'd0;

    typedef struct packed {
        generation_t generation;
        kind_t       kind;
        logic        active;
    } slot_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } gha_state_t;

endpackage

FILE: rtl/gha_if.sv
// Channel interfaces of the generational handle allocator: request and response.
// Each carries valid, ready and the item fields; depends on gha_pkg.
interface gha_req_if;
    logic                   valid;
    logic                   ready;
    gha_pkg::command_t      command;
    gha_pkg::index_field_t  handle_index;
    gha_pkg::generation_t   handle_generation;
    gha_pkg::kind_t         resource_kind;

    modport source (output valid, command, handle_index, handle_generation, resource_kind,
                    input ready);
    modport sink (input valid, command, handle_index, handle_generation, resource_kind,
                  output ready);
endinterface

interface gha_rsp_if;
    logic                   valid;
    logic                   ready;
    gha_pkg::status_t       status;
    logic                   is_valid;
    gha_pkg::index_field_t  out_index;
    gha_pkg::generation_t   out_generation;
    gha_pkg::kind_t         out_kind;

    modport source (output valid, status, is_valid, out_index, out_generation, out_kind,
                    input ready);
    modport sink (input valid, status, is_valid, out_index, out_generation, out_kind,
                  output ready);
endinterface

FILE: rtl/gha_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the slot table and the free stack; depends on nothing.
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/gha_stack.sv
// LIFO free stack of slot indices: a RAM, a depth counter and a cached top entry.
// After a pop the new top is read from the RAM and forwarded in the following cycle.
// Depends on gha_pkg and gha_ram.
module gha_stack #(
    parameter int NUM_SLOTS = gha_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gha_pkg::stack_op_t               op,
    input  logic [$clog2(NUM_SLOTS)-1:0]     push_data,
    output logic [$clog2(NUM_SLOTS+1)-1:0]   count,
    output logic [$clog2(NUM_SLOTS)-1:0]     top
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] top_reg;
    logic [IDX_W-1:0] top_next;
    logic             pending_reg;
    logic             pending_next;
    logic [IDX_W-1:0] rdata;

    assign top   = pending_reg ? rdata : top_reg;
    assign count = count_reg;

    always_comb
    begin
        count_next   = count_reg;
        top_next     = top;
        pending_next = 1'b0;
        if (op.push)
        begin
            count_next = count_reg + CNT_W'(1);
            top_next   = push_data;
        end
        else if (op.pop)
        begin
            count_next   = count_reg - CNT_W'(1);
            pending_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    gha_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (op.push),
        .waddr (IDX_W'(count_reg)),
        .wdata (push_data),
        .re    (op.pop),
        .raddr (IDX_W'(count_reg - CNT_W'(2))),
        .rdata (rdata)
    );

endmodule

FILE: rtl/generational_handle_allocator.sv
// Top level of the generational handle allocator; depends on gha_pkg, gha_if, gha_ram
// and gha_stack.
// Each request item is accepted in S_IDLE and completed in S_EXEC. Its slot entry is read
// from the slot RAM in the accepting cycle, and any write-back is made as the item commits,
// so one item is in flight at a time and no request is taken until the last has committed.
// The slot table and free stack need no clearing after reset; an index is only looked up
// once it has been handed out. A result stays in the response register until taken, and the
// next request may be accepted meanwhile, but it completes only once that register frees.
module generational_handle_allocator #(
    parameter int NUM_SLOTS = gha_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    gha_req_if.sink   request,
    gha_rsp_if.source response
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    gha_pkg::gha_state_t   state_reg;
    gha_pkg::gha_state_t   state_next;

    gha_pkg::command_t     cmd_reg;
    gha_pkg::index_field_t idx_reg;
    gha_pkg::generation_t  gen_reg;
    gha_pkg::kind_t        kind_reg;
    logic [IDX_W-1:0]      addr_reg;
    logic [IDX_W-1:0]      addr_next;

    logic [CNT_W-1:0]      used_reg;
    logic [CNT_W-1:0]      used_next;

    logic                  accept;
    logic                  commit;

    gha_pkg::slot_t        slot_rdata;
    gha_pkg::slot_t        slot_wdata;
    logic                  slot_we;

    gha_pkg::stack_op_t    stack_op;
    logic [CNT_W-1:0]      stack_count;
    logic [IDX_W-1:0]      stack_top;

    logic                  live;

    logic                  rsp_valid_reg;
    gha_pkg::status_t      status_reg;
    gha_pkg::status_t      status_next;
    logic                  is_valid_reg;
    logic                  is_valid_next;
    gha_pkg::index_field_t out_index_reg;
    gha_pkg::index_field_t out_index_next;
    gha_pkg::generation_t  out_gen_reg;
    gha_pkg::generation_t  out_gen_next;
    gha_pkg::kind_t        out_kind_reg;
    gha_pkg::kind_t        out_kind_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gha_pkg::S_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = gha_pkg::S_EXEC;
                end
            end
            gha_pkg::S_EXEC:
            begin
                if (!rsp_valid_reg || response.ready)
                begin
                    state_next = gha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gha_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        request.ready = 1'b0;
        commit        = 1'b0;
        case (state_reg)
            gha_pkg::S_IDLE:
            begin
                request.ready = 1'b1;
            end
            gha_pkg::S_EXEC:
            begin
                commit = !rsp_valid_reg || response.ready;
            end
            default:
            begin
                request.ready = 1'b0;
            end
        endcase
    end

    assign accept = request.valid && request.ready;

    always_comb
    begin
        if (request.command == gha_pkg::CMD_ALLOC)
        begin
            addr_next = (stack_count != '0) ? stack_top : IDX_W'(used_reg);
        end
        else
        begin
            addr_next = IDX_W'(request.handle_index);
        end
    end

    assign live = (gen_reg != '0) && (kind_reg != gha_pkg::KIND_INVALID)
               && (32'(idx_reg) < 32'(used_reg)) && slot_rdata.active
               && (slot_rdata.generation == gen_reg) && (slot_rdata.kind == kind_reg);

    always_comb
    begin
        status_next    = gha_pkg::STATUS_OK;
        is_valid_next  = 1'b0;
        out_index_next = '0;
        out_gen_next   = '0;
        out_kind_next  = '0;
        slot_we        = 1'b0;
        slot_wdata     = slot_rdata;
        stack_op       = '0;
        used_next      = used_reg;
        case (cmd_reg)
            gha_pkg::CMD_ALLOC:
            begin
                if (stack_count != '0)
                begin
                    slot_wdata.generation = slot_rdata.generation + 32'd1;
                    stack_op.pop          = commit;
                    slot_we               = commit;
                end
                else if (used_reg < CNT_W'(NUM_SLOTS))
                begin
                    slot_wdata.generation = 32'd1;
                    used_next             = commit ? used_reg + CNT_W'(1) : used_reg;
                    slot_we               = commit;
                end
                else
                begin
                    status_next = gha_pkg::STATUS_FULL;
                end
                slot_wdata.kind   = kind_reg;
                slot_wdata.active = 1'b1;
                if (status_next == gha_pkg::STATUS_OK)
                begin
                    out_index_next = gha_pkg::index_field_t'(addr_reg);
                    out_gen_next   = slot_wdata.generation;
                    out_kind_next  = kind_reg;
                end
            end
            gha_pkg::CMD_FREE:
            begin
                slot_wdata.kind   = gha_pkg::KIND_INVALID;
                slot_wdata.active = 1'b0;
                if (live && (stack_count < CNT_W'(NUM_SLOTS)))
                begin
                    slot_we       = commit;
                    stack_op.push = commit;
                end
                else
                begin
                    status_next = gha_pkg::STATUS_INVALID;
                end
            end
            gha_pkg::CMD_CHECK:
            begin
                is_valid_next = live;
            end
            default:
            begin
                status_next = gha_pkg::STATUS_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gha_pkg::S_IDLE;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= request.command;
            idx_reg  <= request.handle_index;
            gen_reg  <= request.handle_generation;
            kind_reg <= request.resource_kind;
            addr_reg <= addr_next;
        end
        if (commit)
        begin
            status_reg    <= status_next;
            is_valid_reg  <= is_valid_next;
            out_index_reg <= out_index_next;
            out_gen_reg   <= out_gen_next;
            out_kind_reg  <= out_kind_next;
        end
    end

    gha_ram #(
        .WIDTH ($bits(gha_pkg::slot_t)),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (addr_reg),
        .wdata (slot_wdata),
        .re    (accept),
        .raddr (addr_next),
        .rdata (slot_rdata)
    );

    gha_stack #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (stack_op),
        .push_data (IDX_W'(idx_reg)),
        .count     (stack_count),
        .top       (stack_top)
    );

    assign response.valid          = rsp_valid_reg;
    assign response.status         = status_reg;
    assign response.is_valid       = is_valid_reg;
    assign response.out_index      = out_index_reg;
    assign response.out_generation = out_gen_reg;
    assign response.out_kind       = out_kind_reg;

endmodule

FILE: rtl/gha_checker.sv
// Port-level checker for the generational handle allocator, bound to the top level.
// Depends on gha_pkg and on the port names of generational_handle_allocator.
module gha_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input gha_pkg::status_t      status,
    input logic                  is_valid,
    input gha_pkg::index_field_t out_index,
    input gha_pkg::generation_t  out_generation,
    input gha_pkg::kind_t        out_kind
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while an item is still in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_generation))
        else $error("stalled response item changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status == gha_pkg::STATUS_OK || status == gha_pkg::STATUS_INVALID
                      || status == gha_pkg::STATUS_FULL)
        else $error("response carries an undefined status");

    a_check_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_valid |-> status == gha_pkg::STATUS_OK && out_index == '0
                                  && out_generation == '0 && out_kind == '0)
        else $error("live check result carries allocation fields");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != gha_pkg::STATUS_OK |-> !is_valid && out_generation == '0
                                                      && out_kind == '0)
        else $error("failed item carries result fields");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (request.valid),
    .req_ready      (request.ready),
    .rsp_valid      (response.valid),
    .rsp_ready      (response.ready),
    .status         (response.status),
    .is_valid       (response.is_valid),
    .out_index      (response.out_index),
    .out_generation (response.out_generation),
    .out_kind       (response.out_kind)
);
